[hw/rtl/pbu_pkg.sv]
// Package for the PowerPC branch unit: transaction types, action codes and
// instruction field constants. Shared by pbu_exec and powerpc_branch_unit.
// No dependencies.
package pbu_pkg;

    // Action codes of an input transaction
    localparam logic [1:0] ACT_EXEC   = 2'd0;
    localparam logic [1:0] ACT_WR_LR  = 2'd1;
    localparam logic [1:0] ACT_WR_CTR = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // Primary opcodes and extended opcodes of the branch forms
    localparam logic [5:0] OP_B     = 6'd18;
    localparam logic [5:0] OP_BC    = 6'd16;
    localparam logic [5:0] OP_XL    = 6'd19;
    localparam logic [9:0] XO_BCLR  = 10'd16;
    localparam logic [9:0] XO_BCCTR = 10'd528;

    // Low two bits cleared on register targets
    localparam logic [31:0] ALIGN4_MASK = 32'hffff_fffc;
    localparam logic [31:0] INSTR_BYTES = 32'd4;

    // One input transaction
    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] instr_word;
        logic [31:0] pc;
        logic [31:0] cond_reg;
        logic [31:0] write_value;
    } pbu_item_t;

    // One result transaction, also carries the updated LR and CTR
    typedef struct packed {
        logic        taken;
        logic [31:0] next_pc;
        logic [31:0] link_out;
        logic [31:0] count_out;
        logic        not_branch;
    } pbu_result_t;

endpackage

[hw/rtl/pbu_exec.sv]
// Branch decode and resolve logic: one transaction against current LR/CTR.
// Purely combinational; sits between the input and result registers.
// Depends on pbu_pkg.
module pbu_exec
(
    input  pbu_pkg::pbu_item_t   item,
    input  logic [31:0]          link_cur,
    input  logic [31:0]          count_cur,
    output pbu_pkg::pbu_result_t result
);

    logic [5:0]  op;
    logic [9:0]  xo;
    logic        aa;
    logic        lk;
    logic [4:0]  bo;
    logic [4:0]  bi;
    logic [31:0] pc_plus4;
    logic [31:0] ctr_dec;
    logic        ctr_ok;
    logic        cond_ok;
    logic [31:0] disp;
    logic [31:0] rel_target;
    logic        is_b;
    logic        is_bc;
    logic        is_bclr;
    logic        is_bcctr;

    // Instruction fields, big-endian numbering mapped to vector bits
    assign op = item.instr_word[31:26];
    assign xo = item.instr_word[10:1];
    assign aa = item.instr_word[1];
    assign lk = item.instr_word[0];
    assign bo = item.instr_word[25:21];
    assign bi = item.instr_word[20:16];

    assign is_b     = (op == pbu_pkg::OP_B);
    assign is_bc    = (op == pbu_pkg::OP_BC);
    assign is_bclr  = (op == pbu_pkg::OP_XL) && (xo == pbu_pkg::XO_BCLR);
    assign is_bcctr = (op == pbu_pkg::OP_XL) && (xo == pbu_pkg::XO_BCCTR);

    assign pc_plus4 = item.pc + pbu_pkg::INSTR_BYTES;

    // BO tests: CTR decrement/zero check and CR bit check
    assign ctr_dec = count_cur - 32'd1;
    assign ctr_ok  = bo[2] | ((ctr_dec != 32'd0) != bo[1]);
    assign cond_ok = bo[4] | (item.cond_reg[5'd31 - bi] == bo[3]);

    // Sign-extended displacement for the I-form and B-form
    always_comb
    begin
        if (is_b)
        begin
            disp = {{6{item.instr_word[25]}}, item.instr_word[25:2], 2'b00};
        end
        else
        begin
            disp = {{16{item.instr_word[15]}}, item.instr_word[15:2], 2'b00};
        end
    end

    assign rel_target = aa ? disp : (disp + item.pc);

    // Resolve
    always_comb
    begin
        result.taken      = 1'b0;
        result.next_pc    = 32'd0;
        result.link_out   = link_cur;
        result.count_out  = count_cur;
        result.not_branch = 1'b0;
        unique case (item.action)
            pbu_pkg::ACT_EXEC:
            begin
                result.next_pc = pc_plus4;
                priority if (is_b)
                begin
                    result.taken   = 1'b1;
                    result.next_pc = rel_target;
                end
                else if (is_bc)
                begin
                    if (!bo[2])
                    begin
                        result.count_out = ctr_dec;
                    end
                    if (ctr_ok && cond_ok)
                    begin
                        result.taken   = 1'b1;
                        result.next_pc = rel_target;
                    end
                end
                else if (is_bclr)
                begin
                    if (!bo[2])
                    begin
                        result.count_out = ctr_dec;
                    end
                    // target is LR before any link update
                    if (ctr_ok && cond_ok)
                    begin
                        result.taken   = 1'b1;
                        result.next_pc = link_cur & pbu_pkg::ALIGN4_MASK;
                    end
                end
                else if (is_bcctr)
                begin
                    // no decrement, no CTR test
                    if (cond_ok)
                    begin
                        result.taken   = 1'b1;
                        result.next_pc = count_cur & pbu_pkg::ALIGN4_MASK;
                    end
                end
                else
                begin
                    result.not_branch = 1'b1;
                end
                if ((is_b || is_bc || is_bclr || is_bcctr) && lk)
                begin
                    result.link_out = pc_plus4;
                end
            end
            pbu_pkg::ACT_WR_LR:
            begin
                result.link_out = item.write_value;
            end
            pbu_pkg::ACT_WR_CTR:
            begin
                result.count_out = item.write_value;
            end
            pbu_pkg::ACT_UNUSED:
            begin
                result.link_out = link_cur;
            end
            default:
            begin
                result.link_out = link_cur;
            end
        endcase
    end

endmodule

[hw/rtl/powerpc_branch_unit.sv]
// PowerPC branch unit top level: input register, resolve logic, LR/CTR
// state and result register. Depends on pbu_pkg and pbu_exec.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one transaction per item:
//   an instruction word with pc and condition register, or a write of LR
//   or CTR (action field). Output channel (out_valid/out_stall) returns
//   exactly one result transaction per input: taken, next_pc, the LR and
//   CTR after the item, and not_branch.
//   A transaction accepted on the input passes two register stages,
//   input register and result register. Throughput: one transaction
//   per cycle while out_stall is low. LR and CTR are updated in the
//   same cycle an item resolves, so the next item sees them directly.
//   Stall: while out_stall holds a full result register, the input
//   register still takes one more transaction, then in_stall rises.
//   in_stall follows out_stall combinationally through that path.
//   Reset: rst_n clears LR, CTR and both valid flags; no cleanup pass.
module powerpc_branch_unit
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [31:0] instr_word,
    input  logic [31:0] pc,
    input  logic [31:0] cond_reg,
    input  logic [31:0] write_value,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        taken,
    output logic [31:0] next_pc,
    output logic [31:0] link_out,
    output logic [31:0] count_out,
    output logic        not_branch
);

    logic                 in_valid_reg;
    logic                 in_valid_next;
    pbu_pkg::pbu_item_t   item_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    pbu_pkg::pbu_result_t result_reg;
    pbu_pkg::pbu_result_t result_next;
    logic [31:0]          link_reg;
    logic [31:0]          count_reg;
    logic                 advance;
    logic                 fire;
    logic                 in_accept;

    // Pipeline control
    assign advance   = !out_valid_reg || !out_stall;
    assign fire      = in_valid_reg && advance;
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    assign in_valid_next  = in_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = fire ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    // Resolve logic
    pbu_exec u_exec
    (
        .item      (item_reg),
        .link_cur  (link_reg),
        .count_cur (count_reg),
        .result    (result_next)
    );

    // Control state and architectural registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            link_reg      <= 32'd0;
            count_reg     <= 32'd0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                link_reg  <= result_next.link_out;
                count_reg <= result_next.count_out;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg.action      <= action;
            item_reg.instr_word  <= instr_word;
            item_reg.pc          <= pc;
            item_reg.cond_reg    <= cond_reg;
            item_reg.write_value <= write_value;
        end
        if (fire)
        begin
            result_reg <= result_next;
        end
    end

    // Outputs
    assign out_valid  = out_valid_reg;
    assign taken      = result_reg.taken;
    assign next_pc    = result_reg.next_pc;
    assign link_out   = result_reg.link_out;
    assign count_out  = result_reg.count_out;
    assign not_branch = result_reg.not_branch;

`ifndef SYNTHESIS
    // Stall only with an item held in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg)
        else $error("in_stall without a held item");

    // LR and CTR only change when an item resolves
    assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> ($stable(link_reg) && $stable(count_reg)))
        else $error("LR/CTR changed without a resolved item");

    // A pending result always reports the current LR and CTR
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((link_out == link_reg) && (count_out == count_reg)))
        else $error("result LR/CTR out of step with state");

    // A non-branch word is never taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(taken && not_branch))
        else $error("taken and not_branch both set");
`endif

endmodule

[verif/tb_powerpc_branch_unit.sv]
// Self-checking testbench for powerpc_branch_unit: directed and random
// instruction, LR and CTR transactions, checked against the in-bench branch_scoreboard.
// Depends on pbu_pkg and the powerpc_branch_unit RTL.
`timescale 1ns / 1ps

module tb_powerpc_branch_unit;

    localparam int RANDOM_ITEMS = 2000;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;

    // Tracks LR/CTR and queues the expected result of each accepted transaction
    class branch_scoreboard;
        logic [31:0] lr_shadow;
        logic [31:0] ctr_shadow;
        pbu_pkg::pbu_result_t expected_q[$];
        int unsigned errors;

        function new();
            lr_shadow  = '0;
            ctr_shadow = '0;
            errors     = 0;
        endfunction

        // Resolve one transaction and update the shadow LR/CTR
        function pbu_pkg::pbu_result_t resolve_branch(pbu_pkg::pbu_item_t it);
            pbu_pkg::pbu_result_t r;
            logic [31:0] w;
            logic [5:0]  op;
            logic [9:0]  xo;
            logic [4:0]  bo;
            logic [4:0]  bi;
            logic [31:0] target;
            logic [31:0] old_lr;
            logic        is_br;
            logic        ctr_pass;
            logic        cr_pass;
            r = '0;
            case (it.action)
                pbu_pkg::ACT_EXEC:
                begin
                    w        = it.instr_word;
                    op       = w[31:26];
                    xo       = w[10:1];
                    bo       = w[25:21];
                    bi       = w[20:16];
                    old_lr   = lr_shadow;
                    target   = '0;
                    is_br    = 1'b1;
                    ctr_pass = 1'b1;
                    // CR bit 0 is the MSB of the condition register
                    cr_pass  = bo[4] || (it.cond_reg[5'd31 - bi] == bo[3]);
                    if (op == pbu_pkg::OP_B)
                    begin
                        target = {{6{w[25]}}, w[25:2], 2'b00};
                        if (!w[1])
                            target = target + it.pc;
                        r.taken = 1'b1;
                    end
                    else if (op == pbu_pkg::OP_BC ||
                             (op == pbu_pkg::OP_XL && xo == pbu_pkg::XO_BCLR))
                    begin
                        // BO[2] clear: decrement CTR and test it against BO[1]
                        if (!bo[2])
                        begin
                            ctr_shadow = ctr_shadow - 32'd1;
                            ctr_pass   = (ctr_shadow != 32'd0) != bo[1];
                        end
                        if (op == pbu_pkg::OP_BC)
                        begin
                            target = {{16{w[15]}}, w[15:2], 2'b00};
                            if (!w[1])
                                target = target + it.pc;
                        end
                        else
                            target = old_lr & pbu_pkg::ALIGN4_MASK;
                        r.taken = ctr_pass && cr_pass;
                    end
                    else if (op == pbu_pkg::OP_XL && xo == pbu_pkg::XO_BCCTR)
                    begin
                        // bcctr never touches CTR, whatever BO says
                        target  = ctr_shadow & pbu_pkg::ALIGN4_MASK;
                        r.taken = cr_pass;
                    end
                    else
                        is_br = 1'b0;
                    if (is_br && w[0])
                        lr_shadow = it.pc + pbu_pkg::INSTR_BYTES;
                    r.not_branch = !is_br;
                    r.next_pc    = r.taken ? target : it.pc + pbu_pkg::INSTR_BYTES;
                end
                pbu_pkg::ACT_WR_LR:  lr_shadow  = it.write_value;
                pbu_pkg::ACT_WR_CTR: ctr_shadow = it.write_value;
                default:    ;
            endcase
            r.link_out  = lr_shadow;
            r.count_out = ctr_shadow;
            return r;
        endfunction

        function void record_item(pbu_pkg::pbu_item_t it);
            expected_q.push_back(resolve_branch(it));
        endfunction

        function void check_field(string field, logic [31:0] exp_v, logic [31:0] got_v);
            if (got_v !== exp_v)
            begin
                errors++;
                $display("%0t: %s mismatch: expected %h, actual %h",
                         $time, field, exp_v, got_v);
            end
        endfunction

        function void check_result(pbu_pkg::pbu_result_t got);
            pbu_pkg::pbu_result_t exp_r;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: expected none, actual %h", $time, got);
                return;
            end
            exp_r = expected_q.pop_front();
            check_field("taken",      {31'b0, exp_r.taken},      {31'b0, got.taken});
            check_field("next_pc",    exp_r.next_pc,             got.next_pc);
            check_field("link_out",   exp_r.link_out,            got.link_out);
            check_field("count_out",  exp_r.count_out,           got.count_out);
            check_field("not_branch", {31'b0, exp_r.not_branch}, {31'b0, got.not_branch});
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  action;
    logic [31:0] instr_word;
    logic [31:0] pc;
    logic [31:0] cond_reg;
    logic [31:0] write_value;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        taken;
    logic [31:0] next_pc;
    logic [31:0] link_out;
    logic [31:0] count_out;
    logic        not_branch;

    branch_scoreboard sb;
    int burst_left  = 0;
    int stall_mode  = 0;
    int mode_left   = 0;
    int stall_run   = 0;
    int cycle_count = 0;

    powerpc_branch_unit u_top (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: stall pattern switches between none, light and heavy phases
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            mode_left  <= $urandom_range(20, 150);
        end
        else
            mode_left <= mode_left - 1;

        if (stall_run != 0)
        begin
            out_stall <= 1'b1;
            stall_run <= stall_run - 1;
        end
        else if (stall_mode == 1 && $urandom_range(0, 7) == 0)
        begin
            out_stall <= 1'b1;
            stall_run <= $urandom_range(0, 2);
        end
        else if (stall_mode == 2 && $urandom_range(0, 1) == 0)
        begin
            out_stall <= 1'b1;
            stall_run <= $urandom_range(0, 7);
        end
        else
            out_stall <= 1'b0;
    end

    // Monitor: note accepted inputs first, then check accepted results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.record_item({action, instr_word, pc, cond_reg, write_value});
            if (out_valid && !out_stall)
                sb.check_result({taken, next_pc, link_out, count_out, not_branch});
        end
    end

    // Run limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL powerpc_branch_unit");
        $finish;
    end

    function automatic logic [31:0] enc_b(logic [23:0] li, logic aa, logic lk);
        return {pbu_pkg::OP_B, li, aa, lk};
    endfunction

    function automatic logic [31:0] enc_bc(logic [4:0] bo, logic [4:0] bi, logic [13:0] bd,
                                           logic aa, logic lk);
        return {pbu_pkg::OP_BC, bo, bi, bd, aa, lk};
    endfunction

    function automatic logic [31:0] enc_xl(logic [4:0] bo, logic [4:0] bi, logic [9:0] xo,
                                           logic lk);
        return {pbu_pkg::OP_XL, bo, bi, 5'b00000, xo, lk};
    endfunction

    function automatic pbu_pkg::pbu_item_t exec_item(logic [31:0] word, logic [31:0] addr,
                                                     logic [31:0] cr);
        pbu_pkg::pbu_item_t it;
        it.action      = pbu_pkg::ACT_EXEC;
        it.instr_word  = word;
        it.pc          = addr;
        it.cond_reg    = cr;
        it.write_value = $urandom;
        return it;
    endfunction

    function automatic pbu_pkg::pbu_item_t reg_item(logic [1:0] act, logic [31:0] value);
        pbu_pkg::pbu_item_t it;
        it.action      = act;
        it.instr_word  = $urandom;
        it.pc          = $urandom;
        it.cond_reg    = $urandom;
        it.write_value = value;
        return it;
    endfunction

    // Sender: bursts of random length, random gaps, hold until accepted
    task automatic drive_item(input pbu_pkg::pbu_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid    <= 1'b1;
        action      <= it.action;
        instr_word  <= it.instr_word;
        pc          <= it.pc;
        cond_reg    <= it.cond_reg;
        write_value <= it.write_value;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    initial
    begin
        pbu_pkg::pbu_item_t it;
        logic [31:0] rnd;
        logic [31:0] r2;
        logic [31:0] word;
        logic [31:0] pc_v;
        logic [4:0]  bo;
        logic [4:0]  bi;
        logic        aa;
        logic        lk;
        int          sel;

        sb          = new();
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        action      = pbu_pkg::ACT_EXEC;
        instr_word  = '0;
        pc          = '0;
        cond_reg    = '0;
        write_value = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: offset extremes, BO forms, LR/CTR targets, wrap, non-branches
        drive_item(reg_item(pbu_pkg::ACT_WR_LR, 32'h1234_5679));
        drive_item(reg_item(pbu_pkg::ACT_WR_CTR, 32'd2));
        drive_item(exec_item(enc_b(24'h7f_ffff, 1'b0, 1'b1), 32'h0000_1000, 32'h0));
        drive_item(exec_item(enc_b(24'h80_0000, 1'b0, 1'b0), 32'h0000_0000, 32'h0));
        drive_item(exec_item(enc_b(24'hff_ffff, 1'b1, 1'b0), 32'h0000_4000, 32'h0));
        drive_item(exec_item(enc_bc(5'd16, 5'd0, 14'h1fff, 1'b0, 1'b0), 32'h2000, 32'h0));
        drive_item(exec_item(enc_bc(5'd16, 5'd0, 14'h1fff, 1'b0, 1'b0), 32'h2000, 32'h0));
        // bdz from CTR zero: CTR wraps to all ones
        drive_item(exec_item(enc_bc(5'd18, 5'd0, 14'h2000, 1'b0, 1'b0), 32'h2000, 32'h0));
        drive_item(exec_item(enc_bc(5'd12, 5'd0, 14'h2000, 1'b0, 1'b1), 32'h100,
                             32'h8000_0000));
        drive_item(exec_item(enc_bc(5'd4, 5'd31, 14'h0001, 1'b0, 1'b0), 32'h100,
                             32'hffff_fffe));
        drive_item(exec_item(enc_bc(5'd20, 5'd0, 14'h1fff, 1'b1, 1'b1), 32'h200, 32'h0));
        drive_item(reg_item(pbu_pkg::ACT_WR_LR, 32'h8765_4323));
        drive_item(exec_item(enc_xl(5'd20, 5'd0, pbu_pkg::XO_BCLR, 1'b0), 32'h300, 32'h0));
        // bclrl must branch to the LR value from before the link update
        drive_item(reg_item(pbu_pkg::ACT_WR_LR, 32'h0000_0a02));
        drive_item(exec_item(enc_xl(5'd20, 5'd0, pbu_pkg::XO_BCLR, 1'b1), 32'h3000, 32'h0));
        drive_item(exec_item(enc_xl(5'd0, 5'd5, pbu_pkg::XO_BCLR, 1'b0), 32'h3100, 32'h0));
        drive_item(reg_item(pbu_pkg::ACT_WR_CTR, 32'h0000_5557));
        drive_item(exec_item(enc_xl(5'd20, 5'd0, pbu_pkg::XO_BCCTR, 1'b0), 32'h400, 32'h0));
        // bcctr ignores the decrement bit of BO
        drive_item(exec_item(enc_xl(5'd0, 5'd7, pbu_pkg::XO_BCCTR, 1'b1), 32'h500,
                             32'hffff_ffff));
        drive_item(exec_item(enc_xl(5'd2, 5'd3, pbu_pkg::XO_BCCTR, 1'b1), 32'h600, 32'h0));
        drive_item(reg_item(pbu_pkg::ACT_UNUSED, 32'hffff_ffff));
        drive_item(exec_item(32'hffff_ffff, 32'h700, 32'hffff_ffff));
        drive_item(exec_item({pbu_pkg::OP_XL, 26'h0}, 32'h704, 32'h0));
        drive_item(exec_item(enc_b(24'h00_0001, 1'b0, 1'b1), 32'hffff_fffc, 32'h0));
        drive_item(exec_item(32'h0, 32'h0000_0003, 32'h0));

        // Random: mostly well-formed branches, some register writes and noise
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            rnd = $urandom;
            r2  = $urandom;
            sel = $urandom_range(0, 99);
            bo  = rnd[4:0];
            bi  = rnd[9:5];
            aa  = rnd[10];
            lk  = rnd[11];
            case ($urandom_range(0, 3))
                0:       pc_v = $urandom;
                1:       pc_v = {{28{rnd[13]}}, rnd[15:14], 2'b00};
                default: pc_v = $urandom & pbu_pkg::ALIGN4_MASK;
            endcase
            if (sel < 8)
                it = reg_item(pbu_pkg::ACT_WR_LR, r2);
            else if (sel < 18)
                // small counts often, so the CTR-zero test flips
                it = reg_item(pbu_pkg::ACT_WR_CTR, rnd[12] ? {30'h0, r2[1:0]} : r2);
            else if (sel < 21)
                it = reg_item(pbu_pkg::ACT_UNUSED, r2);
            else
            begin
                if (sel < 36)
                    word = enc_b(r2[23:0], aa, lk);
                else if (sel < 62)
                    word = enc_bc(bo, bi, r2[13:0], aa, lk);
                else if (sel < 75)
                    word = enc_xl(bo, bi, pbu_pkg::XO_BCLR, lk) |
                           {16'h0, r2[15:11], 11'h0};
                else if (sel < 88)
                    word = enc_xl(bo, bi, pbu_pkg::XO_BCCTR, lk) |
                           {16'h0, r2[15:11], 11'h0};
                else if (rnd[16])
                    word = r2;
                else
                    word = {pbu_pkg::OP_XL, r2[25:0]};
                it = exec_item(word, pc_v, $urandom);
            end
            drive_item(it);
        end
        in_valid <= 1'b0;

        // Drain, then give any stray result time to appear
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("PASS powerpc_branch_unit");
        else
            $display("FAIL powerpc_branch_unit");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/pbu_pkg.sv
hw/rtl/pbu_exec.sv
hw/rtl/powerpc_branch_unit.sv
verif/tb_powerpc_branch_unit.sv
